FILE: hdl/fsns_pkg.sv
// Types, codes and character helpers shared by the number token scanner.
package fsns_pkg;

    localparam int ACC_W = 64;

    // number_format codes
    localparam logic [2:0] FMT_DEC  = 3'd0;
    localparam logic [2:0] FMT_UDEC = 3'd1;
    localparam logic [2:0] FMT_BIN  = 3'd2;
    localparam logic [2:0] FMT_OCT  = 3'd3;
    localparam logic [2:0] FMT_HEX  = 3'd4;
    localparam logic [2:0] FMT_BOOL = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT    = 2'd0;
    localparam logic [1:0] REG_TWO_STATE = 2'd1;
    localparam logic [1:0] REG_BITS      = 2'd2;

    // digit decode codes; 0..15 are plain digit values
    localparam logic [4:0] CODE_X   = 5'd16;
    localparam logic [4:0] CODE_Z   = 5'd17;
    localparam logic [4:0] CODE_BAD = 5'd18;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [ACC_W-1:0] value_plane;
        logic [ACC_W-1:0] unknown_plane;
        logic             rejected;
    } t_out_item;

    // per-token scan state
    typedef struct packed {
        logic [ACC_W-1:0] acc_value;
        logic [ACC_W-1:0] acc_unknown;
        logic             sign_negative;
        logic [2:0]       char_count;
        logic [1:0]       digit_count;
        logic             prefix_held;
        logic             unknown_seen;
        logic             all_high_z;
        logic             token_bad;
        logic             true_match;
        logic             false_match;
    } t_tok_state;

    localparam t_tok_state TOK_RESET = '{
        acc_value:     '0,
        acc_unknown:   '0,
        sign_negative: 1'b0,
        char_count:    3'd0,
        digit_count:   2'd0,
        prefix_held:   1'b0,
        unknown_seen:  1'b0,
        all_high_z:    1'b1,
        token_bad:     1'b0,
        true_match:    1'b1,
        false_match:   1'b1
    };

    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        logic [4:0] code;
        if (c >= "0" && c <= "9")
            code = 5'(c - 8'h30);
        else if (c >= "a" && c <= "f")
            code = 5'(c - 8'h57);
        else if (c >= "A" && c <= "F")
            code = 5'(c - 8'h37);
        else if (c == "x" || c == "X" || c == "?")
            code = CODE_X;
        else if (c == "z" || c == "Z")
            code = CODE_Z;
        else
            code = CODE_BAD;
        return code;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
        return r;
    endfunction

    function automatic logic is_prefix_letter(input logic [2:0] fmt, input logic [7:0] c);
        logic hit;
        if (fmt == FMT_BIN)
            hit = (c == "b" || c == "B");
        else if (fmt == FMT_OCT)
            hit = (c == "o" || c == "O");
        else
            hit = (c == "x" || c == "X");
        return hit;
    endfunction

    function automatic logic [7:0] true_letter(input logic [1:0] pos);
        logic [7:0] r;
        unique case (pos)
            2'd0:    r = "t";
            2'd1:    r = "r";
            2'd2:    r = "u";
            default: r = "e";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] false_letter(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "f";
            3'd1:    r = "a";
            3'd2:    r = "l";
            3'd3:    r = "s";
            3'd4:    r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/fsns_accum.sv
// Token state registers and the per-character update of the accumulators.
module fsns_accum import fsns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic [2:0] i_fmt,
    output t_tok_state o_upd
);

    t_tok_state       r_tok;
    t_tok_state       n_tok;
    logic [2:0]       pos;
    logic [7:0]       c;
    logic [7:0]       lc;
    logic [4:0]       code;
    logic [3:0]       field;
    logic [3:0]       dv;
    logic [3:0]       du;
    logic             digit_bad;
    logic [ACC_W-1:0] times_ten;

    assign pos       = r_tok.char_count;
    assign c         = i_item.character;
    assign lc        = to_lower(c);
    assign code      = decode_digit(c);
    assign times_ten = {r_tok.acc_value[ACC_W-4:0], 3'b000}
                     + {r_tok.acc_value[ACC_W-2:0], 1'b0}
                     + {{(ACC_W-4){1'b0}}, code[3:0]};

    always_comb begin
        priority if (i_fmt == FMT_BIN)
            field = 4'h1;
        else if (i_fmt == FMT_OCT)
            field = 4'h7;
        else
            field = 4'hF;

        if (code == CODE_X) begin
            dv = field;
            du = field;
        end else if (code == CODE_Z) begin
            dv = 4'h0;
            du = field;
        end else begin
            dv = code[3:0];
            du = 4'h0;
        end
        digit_bad = (code == CODE_BAD) || (!code[4] && code[3:0] > field);
    end

    always_comb begin
        n_tok = r_tok;
        if (pos != 3'd7)
            n_tok.char_count = pos + 3'd1;

        if (i_fmt == FMT_BOOL) begin
            n_tok.true_match  = r_tok.true_match && !pos[2] && lc == true_letter(pos[1:0]);
            n_tok.false_match = r_tok.false_match && pos <= 3'd4 && lc == false_letter(pos);
        end else if (i_fmt <= FMT_HEX) begin
            if (pos == 3'd0 && (c == "+" || c == "-")) begin
                n_tok.sign_negative = (c == "-");
            end else if (c != "_" && !r_tok.token_bad) begin
                if (r_tok.digit_count != 2'd3)
                    n_tok.digit_count = r_tok.digit_count + 2'd1;
                if (i_fmt <= FMT_UDEC) begin
                    if (!code[4] && code[3:0] <= 4'd9) begin
                        if (r_tok.unknown_seen)
                            n_tok.token_bad = 1'b1;
                        else
                            n_tok.acc_value = times_ten;
                    end else if (code == CODE_X || code == CODE_Z) begin
                        n_tok.unknown_seen = 1'b1;
                        n_tok.all_high_z   = r_tok.all_high_z && code == CODE_Z;
                    end else begin
                        n_tok.token_bad = 1'b1;
                    end
                end else if (r_tok.digit_count == 2'd1 && r_tok.acc_value == '0
                             && r_tok.acc_unknown == '0 && is_prefix_letter(i_fmt, c)) begin
                    // possible 0x / 0b / 0o prefix, settled by the next digit or the end
                    n_tok.prefix_held = 1'b1;
                end else begin
                    n_tok.prefix_held = 1'b0;
                    if (digit_bad) begin
                        n_tok.token_bad = 1'b1;
                    end else begin
                        priority if (i_fmt == FMT_BIN) begin
                            n_tok.acc_value   = {r_tok.acc_value[ACC_W-2:0], dv[0]};
                            n_tok.acc_unknown = {r_tok.acc_unknown[ACC_W-2:0], du[0]};
                        end else if (i_fmt == FMT_OCT) begin
                            n_tok.acc_value   = {r_tok.acc_value[ACC_W-4:0], dv[2:0]};
                            n_tok.acc_unknown = {r_tok.acc_unknown[ACC_W-4:0], du[2:0]};
                        end else begin
                            n_tok.acc_value   = {r_tok.acc_value[ACC_W-5:0], dv};
                            n_tok.acc_unknown = {r_tok.acc_unknown[ACC_W-5:0], du};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= TOK_RESET;
        end else if (i_step) begin
            r_tok <= i_item.last ? TOK_RESET : n_tok;
        end
    end

    assign o_upd = n_tok;

endmodule

FILE: hdl/fsns_finish.sv
// End-of-token resolution: boolean words, width mask, prefix, two-state clearing, sign and rejection.
module fsns_finish import fsns_pkg::*; #(
    parameter int MAX_WIDTH = 64
) (
    input  t_tok_state i_tok,
    input  logic [2:0] i_fmt,
    input  logic       i_two_state,
    input  logic [6:0] i_bits,
    output t_out_item  o_item
);

    localparam logic [6:0] MaxBits = 7'(MAX_WIDTH);

    logic [6:0]       mbits;
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] pv;
    logic [ACC_W-1:0] pu;
    logic [ACC_W-1:0] v;
    logic [ACC_W-1:0] u;
    logic             ok;
    logic             has_unknown;

    assign mbits = (i_bits > MaxBits) ? MaxBits : i_bits;
    assign m     = ~({ACC_W{1'b1}} << mbits);

    always_comb begin
        ok          = 1'b1;
        v           = '0;
        u           = '0;
        pv          = i_tok.acc_value;
        pu          = i_tok.acc_unknown;
        has_unknown = 1'b0;
        if (i_fmt == FMT_BOOL) begin
            if (i_tok.true_match && i_tok.char_count == 3'd4)
                v = {{(ACC_W-1){1'b0}}, 1'b1} & m;
            else if (!(i_tok.false_match && i_tok.char_count == 3'd5))
                ok = 1'b0;
        end else if (i_fmt > FMT_BOOL || i_tok.token_bad || i_tok.digit_count == 2'd0) begin
            ok = 1'b0;
        end else begin
            if (i_fmt >= FMT_BIN && i_tok.prefix_held) begin
                // a bare "0x" reads as 0 then an x digit; bare 0b / 0o is invalid
                if (i_fmt != FMT_HEX)
                    ok = 1'b0;
                pv = {i_tok.acc_value[ACC_W-5:0], 4'hF};
                pu = {i_tok.acc_unknown[ACC_W-5:0], 4'hF};
            end
            if (i_fmt <= FMT_UDEC && i_tok.unknown_seen) begin
                v = i_tok.all_high_z ? '0 : m;
                u = m;
            end else begin
                v = pv & m;
                u = pu & m;
            end
            has_unknown = (u != '0);
            if (i_two_state) begin
                v = v & ~u;
                u = '0;
            end
            if (i_tok.sign_negative) begin
                if (has_unknown && !i_two_state) begin
                    v = m;
                    u = m;
                end else begin
                    v = (~v + {{(ACC_W-1){1'b0}}, 1'b1}) & m;
                end
            end
        end
        o_item.value_plane   = ok ? v : '0;
        o_item.unknown_plane = ok ? u : '0;
        o_item.rejected      = !ok;
    end

endmodule

FILE: hdl/four_state_number_token_scanner_unit.sv
// Four-state number token scanner: top level with config port and request pipeline.
// A token's result goes to the snapshot and then the result register after its last character is accepted.
// Throughput: one character per cycle while o_in_stall is low; input register, state update, snapshot, result.
// With one result waiting and a second held in the snapshot, only the last character
// of the next token stalls; its other characters keep flowing.
// Reset (synchronous, active low) restores config defaults and empties the pipeline.
module four_state_number_token_scanner_unit import fsns_pkg::*; #(
    parameter int MAX_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] r_fmt;
    logic       r_two_state;
    logic [6:0] r_bits;

    logic       r_in_vld;
    t_in_item   r_in;
    logic       r_snap_vld;
    t_tok_state r_snap;
    logic       r_out_vld;
    t_out_item  r_out;

    logic       n_in_vld;
    logic       n_snap_vld;

    logic       out_adv;
    logic       snap_free;
    logic       s1_move;
    logic       in_acc;
    logic       cfg_wr;
    t_tok_state upd;
    t_out_item  fin;

    assign out_adv   = !r_out_vld || !i_out_stall;
    assign snap_free = !r_snap_vld || out_adv;
    assign s1_move   = r_in_vld && (!r_in.last || snap_free);
    assign o_in_stall = r_in_vld && !s1_move;
    assign in_acc    = i_in_valid && !o_in_stall;

    assign n_in_vld   = in_acc || (r_in_vld && !s1_move);
    assign n_snap_vld = (s1_move && r_in.last) || (r_snap_vld && !out_adv);

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_DEC;
            r_two_state <= 1'b0;
            r_bits      <= 7'd32;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FORMAT:    r_fmt       <= pwdata[2:0];
                REG_TWO_STATE: r_two_state <= pwdata[0];
                REG_BITS:      r_bits      <= pwdata[6:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT:    prdata = {29'd0, r_fmt};
            REG_TWO_STATE: prdata = {31'd0, r_two_state};
            REG_BITS:      prdata = {25'd0, r_bits};
            default:       prdata = 32'd0;
        endcase
    end

    fsns_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_move),
        .i_item  (r_in),
        .i_fmt   (r_fmt),
        .o_upd   (upd)
    );

    fsns_finish #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_finish (
        .i_tok       (r_snap),
        .i_fmt       (r_fmt),
        .i_two_state (r_two_state),
        .i_bits      (r_bits),
        .o_item      (fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_snap_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_in_vld   <= n_in_vld;
            r_snap_vld <= n_snap_vld;
            if (out_adv)
                r_out_vld <= r_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_in <= i_in_data;
        if (s1_move && r_in.last)
            r_snap <= upd;
        if (out_adv)
            r_out <= fin;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
